// File: rtl/psa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psa_pkg;

  localparam int PAGE_BYTES_DEF      = 4096;
  localparam int MAX_PAGES_DEF       = 64;
  localparam int MIN_BLOCK_BYTES_DEF = 16;

  localparam int ADDR_W = 18;
  localparam int SIZE_W = 19;
  localparam int CFG_W  = 7;
  localparam int FREE_W = 7;
  localparam int CLS_W  = 4;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_PAGE   = 2'd1,
    ST_NO_RUN    = 2'd2,
    ST_FREED     = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [SIZE_W-1:0]   request_size;
    logic [ADDR_W-1:0]   free_address;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   block_address;
    status_t             status;
    logic [FREE_W-1:0]   free_pages_left;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/psa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/page_slab_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Payload
// in        in   in_valid / in_stall   in_data  (request_t)
// out       out  out_valid / out_stall out_data (result_t)
// cfg       in   cfg_we                cfg_data (pages in use)
//
// One request at a time. A small allocate scans the page descriptors in the
// descriptor memory, then searches the bitmap words of the page for the next free block.
// A large allocate scans the descriptors, marks the run page by page and then compacts
// the free-page stack entry by entry.
// A free clears the block's bit and runs the bitmap search, or releases each page of a run.
// After reset and after each cfg write a clearing pass over all MAX_PAGES pages runs with in_stall high.
// A finished result waits in the output register; the next request is taken meanwhile.

module page_slab_allocator import psa_pkg::*; #(
  parameter int PAGE_BYTES      = PAGE_BYTES_DEF,
  parameter int MAX_PAGES       = MAX_PAGES_DEF,
  parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  request_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output result_t          out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int OFF_W    = $clog2(PAGE_BYTES);
  localparam int LG_MIN   = $clog2(MIN_BLOCK_BYTES);
  localparam int BPP      = PAGE_BYTES / MIN_BLOCK_BYTES;
  localparam int BI_W     = $clog2(BPP);
  localparam int FB_W     = $clog2(BPP + 1);
  localparam int BW       = (BPP < 32) ? BPP : 32;
  localparam int BWL      = $clog2(BW);
  localparam int WPP      = BPP / BW;
  localparam int WC_W     = $clog2(WPP + 1);
  localparam int BM_DEPTH = MAX_PAGES * WPP;
  localparam int BM_AW    = $clog2(BM_DEPTH);
  localparam int PG_W     = $clog2(MAX_PAGES);
  localparam int CNT_W    = $clog2(MAX_PAGES + 1);

  typedef enum logic [1:0] {
    K_FREE  = 2'd0,
    K_SPLIT = 2'd1,
    K_RUN   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CLS_W-1:0]  cls;
    logic [FB_W-1:0]   nfree;
    logic [BI_W-1:0]   first;
    logic [CNT_W-1:0]  runp;
    logic              head;
  } desc_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SA_SCAN, S_SA_RD, S_SA_WR, S_POP, S_POP_W, S_SPLIT,
    S_RUN_SCAN, S_RUN_MARK, S_RUN_STK, S_F_DESC, S_F_CHK, S_F_BM, S_F_BMCHK,
    S_REL, S_FF, S_FF_WB, S_DONE
  } state_t;

  state_t st;

  logic [CNT_W-1:0] piu, cnt, scan_p, len, head, need, idx, lim, kw;
  logic             chk;
  logic [PG_W-1:0]  chk_p, pg;
  logic             is_free;
  logic [CLS_W-1:0] lg;
  logic [OFF_W-1:0] off;
  desc_t            wd;
  logic [BI_W-1:0]  blk, ffirst;
  logic [WC_W-1:0]  fw, fcw;
  logic [ADDR_W-1:0] res_addr;
  status_t          res_st;

  // memory ports
  logic             d_we, s_we, b_we;
  logic [PG_W-1:0]  d_wa, d_ra, s_wa, s_ra, s_wd, s_rd;
  desc_t            d_wd, d_rd;
  logic [BM_AW-1:0] b_wa, b_ra;
  logic [BW-1:0]    b_wd, b_rd;

  psa_ram #(.WIDTH($bits(desc_t)), .DEPTH(MAX_PAGES)) u_desc (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
  );

  psa_ram #(.WIDTH(PG_W), .DEPTH(MAX_PAGES)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );

  psa_ram #(.WIDTH(BW), .DEPTH(BM_DEPTH)) u_bitmap (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd)
  );

  function automatic logic [ADDR_W-1:0] addr_of(input logic [PG_W-1:0] p,
                                                input logic [BI_W-1:0] b,
                                                input logic [CLS_W-1:0] c);
    logic [31:0] a;
    a = (32'(p) << OFF_W) + (32'(b) << c);
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic [31:0] nblk(input logic [CLS_W-1:0] c);
    return 32'(PAGE_BYTES) >> c;
  endfunction

  function automatic logic [BM_AW-1:0] bm_addr(input logic [PG_W-1:0] p, input int w);
    return BM_AW'(int'(p) * WPP + w);
  endfunction

  // request decode
  logic [CLS_W-1:0] req_cls;
  logic [31:0]      need_full, fpage, cfg_sat;
  logic [CNT_W-1:0] cfg_cnt;

  always_comb begin
    logic [4:0] c;
    c = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (32'(in_data.request_size) > (32'd1 << i)) c = 5'(i + 1);
    end
    if (32'(c) < 32'(LG_MIN)) c = 5'(LG_MIN);
    req_cls   = c[CLS_W-1:0];
    need_full = (32'(in_data.request_size) + 32'(PAGE_BYTES - 1)) >> OFF_W;
    fpage     = 32'(in_data.free_address) >> OFF_W;
    if (cfg_data == '0) cfg_sat = 32'd1;
    else if (32'(cfg_data) > 32'(MAX_PAGES)) cfg_sat = 32'(MAX_PAGES);
    else cfg_sat = 32'(cfg_data);
    cfg_cnt = cfg_sat[CNT_W-1:0];
  end

  logic             sa_hit;
  logic [BWL-1:0]   bpos;
  int               bword;
  logic             ff_hit;
  logic [BI_W-1:0]  ff_idx;
  logic             stk_keep;
  logic [CNT_W-1:0] h_new;

  always_comb begin
    logic [31:0] g;
    logic [CNT_W:0] v, lo, hi;
    sa_hit = (d_rd.kind == K_SPLIT) && (d_rd.cls == lg) && (d_rd.nfree != '0);
    bpos   = BWL'(blk % BW);
    bword  = int'(blk / BW);
    ff_hit = 1'b0;
    ff_idx = '0;
    for (int i = 0; i < BW; i++) begin
      g = 32'(fcw) * 32'(BW) + 32'(i);
      if (!ff_hit && !b_rd[i] && g < nblk(wd.cls)) begin
        ff_hit = 1'b1;
        ff_idx = g[BI_W-1:0];
      end
    end
    v        = (CNT_W+1)'(s_rd);
    lo       = (CNT_W+1)'(head);
    hi       = (CNT_W+1)'(head) + (CNT_W+1)'(need);
    stk_keep = !(v >= lo && v < hi);
    h_new    = (len == '0) ? CNT_W'(chk_p) : head;
  end

  // hold requests off while busy or while a cfg write restarts the pool
  assign in_stall = (st != S_IDLE) || cfg_we;

  // memory control
  always_comb begin
    desc_t sd;
    d_we = 1'b0; d_wa = pg; d_wd = '0; d_ra = pg;
    s_we = 1'b0; s_wa = cnt[PG_W-1:0]; s_wd = pg; s_ra = scan_p[PG_W-1:0];
    b_we = 1'b0; b_wa = bm_addr(pg, bword); b_wd = '0; b_ra = bm_addr(pg, bword);
    sd        = '0;
    sd.kind   = K_SPLIT;
    sd.cls    = lg;
    sd.nfree  = FB_W'(nblk(lg) - 32'd1);
    sd.first  = BI_W'(1);
    unique case (st)
      S_CLEAR: begin
        d_we = 1'b1; d_wa = idx[PG_W-1:0];
        s_we = 1'b1; s_wa = idx[PG_W-1:0]; s_wd = idx[PG_W-1:0];
      end
      S_SA_SCAN, S_RUN_SCAN: d_ra = scan_p[PG_W-1:0];
      S_SA_WR: begin
        b_we = 1'b1; b_wd = b_rd | (BW'(1) << bpos);
      end
      S_POP: s_ra = PG_W'(cnt - CNT_W'(1));
      S_SPLIT: begin
        b_we = 1'b1;
        b_wa = bm_addr(pg, int'(fw));
        b_wd = (fw == '0) ? BW'(1) : '0;
        if (fw == '0) begin
          d_we = 1'b1; d_wd = sd;
        end
      end
      S_RUN_MARK: begin
        d_we = 1'b1; d_wa = idx[PG_W-1:0];
        d_wd.kind = K_RUN;
        if (idx == head) begin
          d_wd.runp = need;
          d_wd.head = 1'b1;
        end
      end
      S_RUN_STK: begin
        if (chk && stk_keep) begin
          s_we = 1'b1; s_wa = kw[PG_W-1:0]; s_wd = s_rd;
        end
      end
      S_F_BMCHK: begin
        if (b_rd[bpos]) begin
          b_we = 1'b1; b_wd = b_rd & ~(BW'(1) << bpos);
        end
      end
      S_REL: begin
        if (idx < lim) begin
          d_we = 1'b1; d_wa = idx[PG_W-1:0];
          s_we = (32'(cnt) < 32'(MAX_PAGES)); s_wd = idx[PG_W-1:0];
        end
      end
      S_FF: b_ra = bm_addr(pg, int'(fw));
      S_FF_WB: begin
        d_we = 1'b1;
        if (is_free && 32'(wd.nfree) == nblk(wd.cls)) begin
          s_we = (32'(cnt) < 32'(MAX_PAGES));
        end else begin
          d_wd       = wd;
          d_wd.first = ffirst;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLEAR;
      idx       <= '0;
      piu       <= CNT_W'(MAX_PAGES);
      cnt       <= CNT_W'(MAX_PAGES);
      chk       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (cfg_we || st != S_DONE)) out_valid <= 1'b0;
      if (cfg_we) begin
        piu <= cfg_cnt;
        cnt <= cfg_cnt;
        idx <= '0;
        st  <= S_CLEAR;
      end else begin
        unique case (st)
          S_CLEAR: begin
            idx <= idx + CNT_W'(1);
            if (idx == CNT_W'(MAX_PAGES - 1)) st <= S_IDLE;
          end
          S_IDLE: begin
            if (in_valid) begin
              is_free  <= (in_data.opcode == OP_FREE);
              lg       <= req_cls;
              off      <= in_data.free_address[OFF_W-1:0];
              pg       <= fpage[PG_W-1:0];
              res_addr <= '0;
              scan_p   <= '0;
              chk      <= 1'b0;
              len      <= '0;
              if (in_data.opcode == OP_FREE) begin
                res_st <= ST_FREED;
                st     <= (fpage >= 32'(piu)) ? S_DONE : S_F_DESC;
              end else if (32'(in_data.request_size) < 32'(PAGE_BYTES / 2)) begin
                st <= S_SA_SCAN;
              end else if (need_full > 32'(cnt)) begin
                res_st <= ST_NO_RUN;
                st     <= S_DONE;
              end else begin
                need <= need_full[CNT_W-1:0];
                st   <= S_RUN_SCAN;
              end
            end
          end
          S_SA_SCAN: begin
            chk   <= (scan_p < piu);
            chk_p <= scan_p[PG_W-1:0];
            if (scan_p < piu) scan_p <= scan_p + CNT_W'(1);
            if (chk && sa_hit) begin
              pg  <= chk_p;
              wd  <= d_rd;
              blk <= d_rd.first;
              st  <= S_SA_RD;
            end else if (!chk && scan_p >= piu) begin
              st <= S_POP;
            end
          end
          S_SA_RD: st <= S_SA_WR;
          S_SA_WR: begin
            wd.nfree <= wd.nfree - FB_W'(1);
            res_addr <= addr_of(pg, blk, wd.cls);
            res_st   <= ST_ALLOCATED;
            fw       <= '0;
            chk      <= 1'b0;
            ffirst   <= '0;
            st       <= S_FF;
          end
          S_POP: begin
            if (cnt == '0) begin
              res_st <= ST_NO_PAGE;
              st     <= S_DONE;
            end else begin
              cnt <= cnt - CNT_W'(1);
              st  <= S_POP_W;
            end
          end
          S_POP_W: begin
            pg <= s_rd;
            fw <= '0;
            st <= S_SPLIT;
          end
          S_SPLIT: begin
            fw <= fw + WC_W'(1);
            if (fw == WC_W'(WPP - 1)) begin
              res_addr <= addr_of(pg, '0, '0);
              res_st   <= ST_ALLOCATED;
              st       <= S_DONE;
            end
          end
          S_RUN_SCAN: begin
            chk   <= (scan_p < piu);
            chk_p <= scan_p[PG_W-1:0];
            if (scan_p < piu) scan_p <= scan_p + CNT_W'(1);
            if (chk && d_rd.kind == K_FREE) begin
              head <= h_new;
              len  <= len + CNT_W'(1);
              if (len + CNT_W'(1) == need) begin
                idx <= h_new;
                st  <= S_RUN_MARK;
              end
            end else if (chk) begin
              len <= '0;
            end else if (scan_p >= piu) begin
              res_st <= ST_NO_RUN;
              st     <= S_DONE;
            end
          end
          S_RUN_MARK: begin
            idx <= idx + CNT_W'(1);
            if ((CNT_W+1)'(idx) + (CNT_W+1)'(1) == (CNT_W+1)'(head) + (CNT_W+1)'(need)) begin
              scan_p <= '0;
              chk    <= 1'b0;
              kw     <= '0;
              st     <= S_RUN_STK;
            end
          end
          S_RUN_STK: begin
            // compact the stack, dropping pages of the new run
            chk <= (scan_p < cnt);
            if (scan_p < cnt) scan_p <= scan_p + CNT_W'(1);
            if (chk && stk_keep) kw <= kw + CNT_W'(1);
            if (!chk && scan_p >= cnt) begin
              cnt      <= kw;
              res_addr <= addr_of(head[PG_W-1:0], '0, '0);
              res_st   <= ST_ALLOCATED;
              st       <= S_DONE;
            end
          end
          S_F_DESC: st <= S_F_CHK;
          S_F_CHK: begin
            wd <= d_rd;
            if (d_rd.kind == K_RUN) begin
              if (d_rd.head) begin
                idx <= CNT_W'(pg);
                if ((CNT_W+1)'(pg) + (CNT_W+1)'(d_rd.runp) < (CNT_W+1)'(piu)) begin
                  lim <= CNT_W'(pg) + d_rd.runp;
                end else begin
                  lim <= piu;
                end
                st <= S_REL;
              end else begin
                st <= S_DONE;
              end
            end else if (d_rd.kind == K_SPLIT) begin
              blk <= BI_W'(off >> d_rd.cls);
              st  <= S_F_BM;
            end else begin
              st <= S_DONE;
            end
          end
          S_REL: begin
            if (idx < lim) begin
              idx <= idx + CNT_W'(1);
              if (32'(cnt) < 32'(MAX_PAGES)) cnt <= cnt + CNT_W'(1);
            end else begin
              st <= S_DONE;
            end
          end
          S_F_BM: st <= S_F_BMCHK;
          S_F_BMCHK: begin
            if (b_rd[bpos]) begin
              wd.nfree <= wd.nfree + FB_W'(1);
              fw       <= '0;
              chk      <= 1'b0;
              ffirst   <= '0;
              st       <= S_FF;
            end else begin
              st <= S_DONE;
            end
          end
          S_FF: begin
            // lowest clear bit among the page's blocks, one word a cycle
            chk <= (32'(fw) < 32'(WPP));
            fcw <= fw;
            if (32'(fw) < 32'(WPP)) fw <= fw + WC_W'(1);
            if (chk && ff_hit) begin
              ffirst <= ff_idx;
              st     <= S_FF_WB;
            end else if (!chk && 32'(fw) >= 32'(WPP)) begin
              st <= S_FF_WB;
            end
          end
          S_FF_WB: begin
            if (is_free && 32'(wd.nfree) == nblk(wd.cls) && 32'(cnt) < 32'(MAX_PAGES)) begin
              cnt <= cnt + CNT_W'(1);
            end
            st <= S_DONE;
          end
          S_DONE: begin
            if (!out_valid || !out_stall) begin
              out_valid                <= 1'b1;
              out_data.block_address   <= res_addr;
              out_data.status          <= res_st;
              out_data.free_pages_left <= FREE_W'(cnt);
              st                       <= S_IDLE;
            end
          end
          default: st <= S_IDLE;
        endcase
      end
    end
  end

endmodule

`default_nettype wire
